// ===== hw/rtl/sstc_pkg.sv =====
// sstc_pkg: shared codes, widths and transaction types for the slew trigger capture block.
// No dependencies; used by every module under hw/rtl.
package sstc_pkg;

  localparam int SampleW     = 12;
  localparam int OffsetW     = 7;
  localparam int ActionW     = 2;
  localparam int KindW       = 2;
  localparam int ModeW       = 2;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 12;
  localparam int QueueDepth  = 2;

  localparam int RingDepthDef  = 1024;
  localparam int HalfWindowDef = 64;

  localparam logic [SampleW-1:0] ThresholdRst = 12'd500;

  // input actions
  localparam logic [ActionW-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ActionW-1:0] ACT_LATCH  = 2'd1;
  localparam logic [ActionW-1:0] ACT_READ   = 2'd2;

  // trigger modes
  localparam logic [ModeW-1:0] MODE_RISE = 2'd0;
  localparam logic [ModeW-1:0] MODE_FALL = 2'd1;
  localparam logic [ModeW-1:0] MODE_BOTH = 2'd2;
  localparam logic [ModeW-1:0] MODE_FREE = 2'd3;

  // window kinds reported on a latch
  localparam logic [KindW-1:0] KIND_NONE = 2'd0;
  localparam logic [KindW-1:0] KIND_TRIG = 2'd1;
  localparam logic [KindW-1:0] KIND_FREE = 2'd2;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAUSED    = 2'd2;

  // memory operations carried from front to back
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } mem_op_e;

  // control part of one queued command (address travels beside it)
  typedef struct packed {
    mem_op_e              op;
    logic                 unwritten;  // read hits a slot never written since reset
    logic [SampleW-1:0]   data;
    logic [KindW-1:0]     kind;
    logic                 done;
  } cmd_ctrl_t;

  // one finished result
  typedef struct packed {
    logic [SampleW-1:0] read_value;
    logic [KindW-1:0]   window_kind;
    logic               capture_done;
  } result_t;

  // queue status handed to the top level
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== hw/rtl/sstc_queue.sv =====
// sstc_queue: small register FIFO, used for the command queue and the result skid buffer.
// Depends on sstc_pkg for the status struct.
module sstc_queue #(
  parameter int Width = 8,
  parameter int Depth = sstc_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           din_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           dout_o,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output sstc_pkg::q_status_t        status_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntW'(Depth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

  assign dout_o         = mem_q[rd_q];
  assign count_o        = cnt_q;
  assign status_o.push  = push_i;
  assign status_o.pop   = pop_i;
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.valid = (cnt_q != '0);

endmodule

// ===== hw/rtl/sstc_front.sv =====
// sstc_front: config registers, trigger detection, window bookkeeping; turns each
// transaction into one memory command. Depends on sstc_pkg.
module sstc_front #(
  parameter int RingDepth  = sstc_pkg::RingDepthDef,
  parameter int HalfWindow = sstc_pkg::HalfWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sstc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sstc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          take_i,
  input  logic [sstc_pkg::ActionW-1:0]  action_i,
  input  logic [sstc_pkg::SampleW-1:0]  sample_i,
  input  logic [sstc_pkg::OffsetW-1:0]  offset_i,
  output logic [$clog2(RingDepth)-1:0]  cmd_addr_o,
  output sstc_pkg::cmd_ctrl_t           cmd_ctrl_o
);

  localparam int AW       = $clog2(RingDepth);
  localparam int CntW     = $clog2(HalfWindow + 2);
  localparam int FreeDist = (1 + 2 * HalfWindow) % RingDepth;
  localparam int SW       = sstc_pkg::SampleW;

  // config
  logic [sstc_pkg::ModeW-1:0] mode_q;
  logic [SW-1:0]              thr_q;
  logic                       paused_q;

  // capture state
  logic [AW-1:0]   wp_q, wp_d;
  logic            filled_q, filled_d;
  logic [SW-1:0]   last_q, last_d;
  logic            armed_q, armed_d;
  logic [CntW-1:0] post_q, post_d;
  logic [AW-1:0]   cand_q, cand_d;
  logic [AW-1:0]   dslot_q, dslot_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   base_q, base_d;

  logic            rise, fall, fires;
  logic [CntW-1:0] post_inc;
  logic [AW:0]     rd_sum;
  logic [AW-1:0]   rd_addr;

  assign rise = {1'b0, sample_i} > ({1'b0, last_q} + {1'b0, thr_q});
  assign fall = {1'b0, last_q} > ({1'b0, sample_i} + {1'b0, thr_q});

  always_comb begin
    case (mode_q)
      sstc_pkg::MODE_RISE: fires = rise;
      sstc_pkg::MODE_FALL: fires = fall;
      sstc_pkg::MODE_BOTH: fires = rise || fall;
      default:             fires = 1'b0;
    endcase
  end

  assign post_inc = post_q + 1'b1;
  assign rd_sum   = {1'b0, base_q} + (AW+1)'(offset_i);
  assign rd_addr  = (rd_sum >= (AW+1)'(RingDepth)) ?
                    AW'(rd_sum - (AW+1)'(RingDepth)) : AW'(rd_sum);

  always_comb begin
    wp_d     = wp_q;
    filled_d = filled_q;
    last_d   = last_q;
    armed_d  = armed_q;
    post_d   = post_q;
    cand_d   = cand_q;
    dslot_d  = dslot_q;
    pend_d   = pend_q;
    base_d   = base_q;
    cmd_addr_o           = wp_q;
    cmd_ctrl_o.op        = sstc_pkg::OP_NONE;
    cmd_ctrl_o.unwritten = 1'b0;
    cmd_ctrl_o.data      = sample_i;
    cmd_ctrl_o.kind      = sstc_pkg::KIND_NONE;
    cmd_ctrl_o.done      = 1'b0;
    case (action_i)
      sstc_pkg::ACT_SAMPLE: begin
        if (!paused_q) begin
          cmd_ctrl_o.op = sstc_pkg::OP_WRITE;
          if (!armed_q) begin
            if (fires) begin
              post_d  = '0;
              cand_d  = wp_q;
              armed_d = 1'b1;
            end
          end else begin
            post_d = post_inc;
            if (post_inc > CntW'(HalfWindow)) begin
              armed_d         = 1'b0;
              dslot_d         = cand_q;
              pend_d          = 1'b1;
              cmd_ctrl_o.done = 1'b1;
            end
          end
          if (wp_q == AW'(RingDepth - 1)) begin
            wp_d     = '0;
            filled_d = 1'b1;
          end else begin
            wp_d = wp_q + 1'b1;
          end
          last_d = sample_i;
        end
      end
      sstc_pkg::ACT_LATCH: begin
        if (!paused_q) begin
          if (pend_q) begin
            base_d = (dslot_q >= AW'(HalfWindow)) ? dslot_q - AW'(HalfWindow) :
                     AW'({1'b0, dslot_q} + (AW+1)'(RingDepth - HalfWindow));
            pend_d = 1'b0;
            cmd_ctrl_o.kind = sstc_pkg::KIND_TRIG;
          end else if (mode_q == sstc_pkg::MODE_FREE) begin
            base_d = (wp_q >= AW'(FreeDist)) ? wp_q - AW'(FreeDist) :
                     AW'({1'b0, wp_q} + (AW+1)'(RingDepth - FreeDist));
            cmd_ctrl_o.kind = sstc_pkg::KIND_FREE;
          end
        end
      end
      sstc_pkg::ACT_READ: begin
        cmd_addr_o           = rd_addr;
        cmd_ctrl_o.op        = sstc_pkg::OP_READ;
        // slots past the fill point were never written; the read stage returns zero for them
        cmd_ctrl_o.unwritten = !filled_q && (rd_addr >= wp_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sstc_pkg::MODE_RISE;
      thr_q    <= sstc_pkg::ThresholdRst;
      paused_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sstc_pkg::CFG_MODE:      mode_q   <= cfg_wdata_i[sstc_pkg::ModeW-1:0];
        sstc_pkg::CFG_THRESHOLD: thr_q    <= cfg_wdata_i[SW-1:0];
        sstc_pkg::CFG_PAUSED:    paused_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      filled_q <= 1'b0;
      last_q   <= '0;
      armed_q  <= 1'b0;
      post_q   <= '0;
      cand_q   <= '0;
      dslot_q  <= '0;
      pend_q   <= 1'b0;
      base_q   <= '0;
    end else if (take_i) begin
      wp_q     <= wp_d;
      filled_q <= filled_d;
      last_q   <= last_d;
      armed_q  <= armed_d;
      post_q   <= post_d;
      cand_q   <= cand_d;
      dslot_q  <= dslot_d;
      pend_q   <= pend_d;
      base_q   <= base_d;
    end
  end

endmodule

// ===== hw/rtl/sstc_back.sv =====
// sstc_back: sample ring memory, registered read stage and result skid buffer.
// Depends on sstc_pkg and sstc_queue.
module sstc_back #(
  parameter int RingDepth = sstc_pkg::RingDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  logic [$clog2(RingDepth)-1:0] cmd_addr_i,
  input  sstc_pkg::cmd_ctrl_t          cmd_ctrl_i,
  output logic                         cmd_pop_o,
  output sstc_pkg::result_t            res_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output sstc_pkg::q_status_t          oq_status_o
);

  localparam int SW   = sstc_pkg::SampleW;
  localparam int OCntW = $clog2(sstc_pkg::QueueDepth + 1);

  logic [SW-1:0] ring_q [RingDepth];
  logic [SW-1:0] rdata_q;

  logic                s1_valid_q;
  sstc_pkg::cmd_ctrl_t s1_ctrl_q;
  sstc_pkg::result_t   s1_res;
  logic [OCntW-1:0]    oq_count;
  logic                oq_pop;
  logic [OCntW+1:0]    room_need;

  assign oq_pop = res_valid_o && res_ready_i;

  // issue only when the skid buffer can hold everything in flight plus this one
  assign room_need = (OCntW+2)'(oq_count) + (OCntW+2)'(s1_valid_q) + 1'b1
                   - (OCntW+2)'(oq_pop);
  assign cmd_pop_o = cmd_valid_i && (room_need <= (OCntW+2)'(sstc_pkg::QueueDepth));

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_ctrl_i.op == sstc_pkg::OP_WRITE)) begin
      ring_q[cmd_addr_i] <= cmd_ctrl_i.data;
    end
    if (cmd_pop_o && (cmd_ctrl_i.op == sstc_pkg::OP_READ)) begin
      rdata_q <= ring_q[cmd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_ctrl_q <= cmd_ctrl_i;
    end
  end

  assign s1_res.read_value   = ((s1_ctrl_q.op == sstc_pkg::OP_READ) && !s1_ctrl_q.unwritten) ?
                               rdata_q : '0;
  assign s1_res.window_kind  = s1_ctrl_q.kind;
  assign s1_res.capture_done = s1_ctrl_q.done;

  sstc_queue #(
    .Width ($bits(sstc_pkg::result_t)),
    .Depth (sstc_pkg::QueueDepth)
  ) u_out_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (s1_valid_q),
    .din_i    (s1_res),
    .pop_i    (oq_pop),
    .dout_o   (res_o),
    .count_o  (oq_count),
    .status_o (oq_status_o)
  );

  assign res_valid_o = oq_status_o.valid;

endmodule

// ===== hw/rtl/scope_slew_trigger_capture.sv =====
// scope_slew_trigger_capture: top level of the slew-trigger ring capture block.
// Depends on sstc_pkg, sstc_front, sstc_queue and sstc_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_ready_o | action_i, sample_i, offset_i
//   out     | output    | out_valid_o/out_ready_i | read_value_o, window_kind_o, capture_done_o
//   cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle sustained while out_ready_i holds. A transaction
// passes the command queue, ring memory read register and result skid buffer.
// The single-port ring memory (one write or one read per cycle) sets the rate.
// Reset clears all control and capture state; ring slots not yet written since
// reset read as zero via the fill pointer, so there is no clearing pass.
// A stalled output fills the skid buffer, then the command queue, then drops
// in_ready_o; each side stalls independently.
module scope_slew_trigger_capture #(
  parameter int RING_DEPTH  = sstc_pkg::RingDepthDef,
  parameter int HALF_WINDOW = sstc_pkg::HalfWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [sstc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sstc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sstc_pkg::ActionW-1:0]  action_i,
  input  logic [sstc_pkg::SampleW-1:0]  sample_i,
  input  logic [sstc_pkg::OffsetW-1:0]  offset_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sstc_pkg::SampleW-1:0]  read_value_o,
  output logic [sstc_pkg::KindW-1:0]    window_kind_o,
  output logic                          capture_done_o
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CmdW = AW + $bits(sstc_pkg::cmd_ctrl_t);
  localparam int QCntW = $clog2(sstc_pkg::QueueDepth + 1);

  logic                take;
  logic [AW-1:0]       f_addr, b_addr;
  sstc_pkg::cmd_ctrl_t f_ctrl, b_ctrl;
  logic                cmd_pop;
  logic [QCntW-1:0]    cq_count;
  sstc_pkg::q_status_t cq_status, oq_status;
  sstc_pkg::result_t   res;

  // front updates its capture state only on an accepted transaction
  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = !cq_status.full;

  sstc_front #(
    .RingDepth  (RING_DEPTH),
    .HalfWindow (HALF_WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .offset_i    (offset_i),
    .cmd_addr_o  (f_addr),
    .cmd_ctrl_o  (f_ctrl)
  );

  // command queue decouples classification from memory access
  sstc_queue #(
    .Width (CmdW),
    .Depth (sstc_pkg::QueueDepth)
  ) u_cmd_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (take),
    .din_i    ({f_addr, f_ctrl}),
    .pop_i    (cmd_pop),
    .dout_o   ({b_addr, b_ctrl}),
    .count_o  (cq_count),
    .status_o (cq_status)
  );

  sstc_back #(
    .RingDepth (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cq_status.valid),
    .cmd_addr_i  (b_addr),
    .cmd_ctrl_i  (b_ctrl),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .oq_status_o (oq_status)
  );

  assign read_value_o   = res.read_value;
  assign window_kind_o  = res.window_kind;
  assign capture_done_o = res.capture_done;

  // ---------------------------------------------------------------- checks
  // the command queue is never pushed while full
  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_status.push |-> !cq_status.full)
    else $error("command queue overflow");

  // the back end never pops an empty command queue
  a_cmd_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (cq_count != '0))
    else $error("command queue underflow");

  // the read stage never pushes into a full skid buffer that is not draining
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_status.push |-> (!oq_status.full || oq_status.pop))
    else $error("result buffer overflow");

  // every command popped turns into a result push on the next cycle
  a_pop_to_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> oq_status.push)
    else $error("issued command lost in read stage");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for scope_slew_trigger_capture.
// Depends on sstc_pkg and the scope_slew_trigger_capture RTL; needs no other files.
// Drives samples, latches and reads under random idling and checks every result.
module tb;
  import sstc_pkg::*;

  // action code the block must ignore
  localparam logic [ActionW-1:0] ACT_NONE = 2'd3;

  localparam int RingAw  = $clog2(RingDepthDef);
  localparam int HalfWin = HalfWindowDef;
  localparam int ItemGoal = 1550;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [SampleW-1:0] sample;
    logic [OffsetW-1:0] offset;
  } scope_item_t;

  // clock, reset and block ports; every input starts at a known value
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [ActionW-1:0]  action_i       = '0;
  logic [SampleW-1:0]  sample_i       = '0;
  logic [OffsetW-1:0]  offset_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [SampleW-1:0]  read_value_o;
  logic [KindW-1:0]    window_kind_o;
  logic                capture_done_o;

  scope_slew_trigger_capture u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .sample_i       (sample_i),
    .offset_i       (offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .window_kind_o  (window_kind_o),
    .capture_done_o (capture_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the capture engine: ring image, trigger state and register copies.
  // Reset values match the block's reset; reset happens once, so these
  // initializers are the whole reset of the shadow.
  // ---------------------------------------------------------------------------
  logic [SampleW-1:0] ring_img [RingDepthDef];
  logic [RingAw-1:0]  wr_ptr      = '0;
  logic [SampleW-1:0] prev_smp    = '0;
  logic               armed       = 1'b0;
  logic [6:0]         post_cnt    = '0;
  logic [RingAw-1:0]  cand_slot   = '0;
  logic [RingAw-1:0]  done_slot   = '0;
  logic               win_pending = 1'b0;
  logic [RingAw-1:0]  win_base    = '0;

  logic [ModeW-1:0]   mode_cfg    = MODE_RISE;
  logic [SampleW-1:0] thr_cfg     = ThresholdRst;
  logic               paused_cfg  = 1'b0;

  scope_item_t  item_q[$];     // transactions waiting for the driver
  result_t      readout_q[$];  // expected results, oldest first

  int unsigned n_pushed, n_checked, n_err, n_phase;
  int unsigned n_smp, n_latch, n_trig_win, n_free_win, n_read, n_done;
  bit          steady_flow;    // no idling on either side while set

  // Advance the shadow by one accepted transaction and return its result.
  function automatic result_t compute_readout(scope_item_t it);
    result_t           r;
    int                diff;
    int                thr;
    logic              fire;
    logic [RingAw-1:0] idx;
    r    = '0;
    thr  = int'(thr_cfg);
    fire = 1'b0;
    if (it.action == ACT_SAMPLE && !paused_cfg) begin
      n_smp++;
      ring_img[wr_ptr] = it.sample;
      if (!armed) begin
        diff = int'(it.sample) - int'(prev_smp);
        case (mode_cfg)
          MODE_RISE: fire = diff > thr;
          MODE_FALL: fire = -diff > thr;
          MODE_BOTH: fire = (diff > thr) || (-diff > thr);
          default:   fire = 1'b0;
        endcase
        if (fire) begin
          post_cnt  = '0;
          cand_slot = wr_ptr;
          armed     = 1'b1;
        end
      end else begin
        // count keeps running even if the mode changed since the trigger
        post_cnt++;
        if (int'(post_cnt) > HalfWin) begin
          armed          = 1'b0;
          done_slot      = cand_slot;
          win_pending    = 1'b1;
          r.capture_done = 1'b1;
          n_done++;
        end
      end
      wr_ptr++;
      prev_smp = it.sample;
    end else if (it.action == ACT_LATCH && !paused_cfg) begin
      n_latch++;
      // a completed trigger window wins, even in free-running mode
      if (win_pending) begin
        win_base      = done_slot - RingAw'(HalfWin);
        win_pending   = 1'b0;
        r.window_kind = KIND_TRIG;
        n_trig_win++;
      end else if (mode_cfg == MODE_FREE) begin
        win_base      = wr_ptr - RingAw'(2 * HalfWin + 1);
        r.window_kind = KIND_FREE;
        n_free_win++;
      end
    end else if (it.action == ACT_READ) begin
      // reads work while paused, against the last latched base
      n_read++;
      idx          = win_base + RingAw'(it.offset);
      r.read_value = ring_img[idx];
    end
    return r;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes the next transaction from item_q, holds it until accepted,
  // then idles for a random gap. The shadow is advanced at acceptance.
  // ---------------------------------------------------------------------------
  scope_item_t drv_item;
  int unsigned drv_gap;

  always @(posedge clk_i) begin : drv
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        readout_q.push_back(compute_readout(drv_item));
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the current transaction
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_valid_i <= 1'b0;
      end else if (item_q.size() != 0) begin
        drv_item = item_q.pop_front();
        action_i   <= drv_item.action;
        sample_i   <= drv_item.sample;
        offset_i   <= drv_item.offset;
        in_valid_i <= 1'b1;
        drv_gap    = idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expectation and
  // stalls the output side at random.
  // ---------------------------------------------------------------------------
  int unsigned mon_stall;

  always @(posedge clk_i) begin : mon
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (readout_q.size() == 0) begin
          $error("result with no expectation: read_value %0d window_kind %0d capture_done %0d",
                 read_value_o, window_kind_o, capture_done_o);
          n_err++;
        end else begin
          want = readout_q.pop_front();
          n_checked++;
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, read_value_o);
            n_err++;
          end
          if (window_kind_o !== want.window_kind) begin
            $error("window_kind: expected %0d, got %0d", want.window_kind, window_kind_o);
            n_err++;
          end
          if (capture_done_o !== want.capture_done) begin
            $error("capture_done: expected %0d, got %0d", want.capture_done, capture_done_o);
            n_err++;
          end
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        mon_stall = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Only transactions the block acts on count toward the goal.
  function automatic int unsigned push_item(logic [ActionW-1:0] act, int unsigned smp,
                                            int unsigned off);
    scope_item_t it;
    it.action = act;
    it.sample = SampleW'(smp);
    it.offset = OffsetW'(off);
    item_q.push_back(it);
    n_pushed++;
    if (act == ACT_READ) return 1;
    if ((act == ACT_SAMPLE || act == ACT_LATCH) && !paused_cfg) return 1;
    return 0;
  endfunction

  // Block is idle once every pushed transaction has produced its result;
  // then allow the pipeline latency to pass.
  task automatic wait_idle();
    while (n_checked != n_pushed) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:      mode_cfg   = ModeW'(val);
      CFG_THRESHOLD: thr_cfg    = SampleW'(val);
      CFG_PAUSED:    paused_cfg = val[0];
      default: ;
    endcase
  endtask

  // Waveform with small drift and occasional big steps, long enough to run a
  // full post-trigger count, followed by a latch and a few reads.
  function automatic int unsigned push_capture_burst();
    int          lvl;
    int unsigned cnt;
    cnt = 0;
    lvl = int'($urandom_range(0, 4095));
    repeat ($urandom_range(66, 110)) begin
      if ($urandom_range(0, 99) < 6) lvl = int'($urandom_range(0, 4095));
      else lvl = lvl + int'($urandom_range(0, 40)) - 20;
      if (lvl < 0) lvl = 0;
      if (lvl > 4095) lvl = 4095;
      cnt += push_item(ACT_SAMPLE, lvl, $urandom_range(0, 127));
    end
    cnt += push_item(ACT_LATCH, $urandom_range(0, 4095), $urandom_range(0, 127));
    repeat ($urandom_range(2, 8))
      cnt += push_item(ACT_READ, $urandom_range(0, 4095), $urandom_range(0, 127));
    return cnt;
  endfunction

  function automatic int unsigned push_burst();
    int unsigned r, cnt;
    cnt = 0;
    r   = $urandom_range(0, 99);
    if (r < 45) begin
      cnt = push_capture_burst();
    end else if (r < 60) begin
      cnt += push_item(ACT_LATCH, $urandom_range(0, 4095), $urandom_range(0, 127));
      repeat ($urandom_range(2, 8))
        cnt += push_item(ACT_READ, $urandom_range(0, 4095), $urandom_range(0, 127));
    end else if (r < 75) begin
      repeat ($urandom_range(4, 10))
        cnt += push_item(ACT_READ, $urandom_range(0, 4095), $urandom_range(0, 127));
    end else if (r < 85) begin
      // rail-to-rail jumps
      repeat ($urandom_range(5, 20))
        cnt += push_item(ACT_SAMPLE, $urandom_range(0, 1) ? 4095 - $urandom_range(0, 300) :
                         $urandom_range(0, 300), $urandom_range(0, 127));
    end else begin
      // noise: any action code, any field content
      repeat ($urandom_range(6, 12))
        cnt += push_item(ActionW'($urandom_range(0, 3)), $urandom_range(0, 4095),
                         $urandom_range(0, 127));
    end
    return cnt;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned n_counted, phase_cnt, r;
    int unsigned mode_sel, thr_sel, paused_sel;
    n_counted = 0;
    foreach (ring_img[i]) ring_img[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reads of the cleared ring, latch with nothing pending,
    // ignored action code, a jump equal to the threshold, one just above it.
    n_counted += push_item(ACT_READ, 0, 0);
    n_counted += push_item(ACT_READ, 4095, 127);
    n_counted += push_item(ACT_LATCH, 0, 0);
    n_counted += push_item(ACT_NONE, 4095, 127);
    n_counted += push_item(ACT_SAMPLE, 0, 0);
    n_counted += push_item(ACT_SAMPLE, 500, 127);
    n_counted += push_item(ACT_SAMPLE, 1001, 0);
    n_counted += push_item(ACT_SAMPLE, 4095, 0);
    wait_idle();
    // mode change while armed, free-running latch on top of it
    cfg_write(CFG_MODE, MODE_FREE);
    n_counted += push_item(ACT_LATCH, 4095, 0);
    n_counted += push_item(ACT_READ, 0, 127);
    n_counted += push_item(ACT_READ, 0, 1);
    wait_idle();
    // paused: samples and latches frozen, reads still served
    cfg_write(CFG_PAUSED, 1);
    n_counted += push_item(ACT_SAMPLE, 4095, 0);
    n_counted += push_item(ACT_LATCH, 0, 0);
    n_counted += push_item(ACT_READ, 0, 3);
    wait_idle();
    cfg_write(CFG_PAUSED, 0);
    cfg_write(CFG_MODE, MODE_FALL);
    cfg_write(CFG_THRESHOLD, 4095);
    n_counted += push_item(ACT_SAMPLE, 4095, 0);
    n_counted += push_item(ACT_SAMPLE, 0, 127);
    n_counted += push_item(ACT_LATCH, 0, 0);
    wait_idle();

    // Random phases; each starts from an idle block with a fresh setting.
    n_phase = 0;
    while (n_counted < ItemGoal) begin
      case (n_phase)
        0:       begin mode_sel = MODE_RISE; thr_sel = 0;    paused_sel = 0; end
        1:       begin mode_sel = MODE_FALL; thr_sel = 4095; paused_sel = 0; end
        2:       begin mode_sel = MODE_BOTH; thr_sel = 500;  paused_sel = 0; end
        3:       begin mode_sel = MODE_BOTH; thr_sel = 200;  paused_sel = 1; end
        4:       begin mode_sel = MODE_FREE; thr_sel = 0;    paused_sel = 0; end
        default: begin
          mode_sel   = $urandom_range(0, 3);
          paused_sel = ($urandom_range(0, 7) == 0);
          r = $urandom_range(0, 5);
          thr_sel = (r == 0) ? 0 : (r == 1) ? 4095 : (r == 2) ? 500 : $urandom_range(20, 1500);
        end
      endcase
      wait_idle();
      cfg_write(CFG_MODE, mode_sel);
      cfg_write(CFG_THRESHOLD, thr_sel);
      cfg_write(CFG_PAUSED, paused_sel);
      phase_cnt = 0;
      if (paused_cfg) begin
        repeat (20)
          n_counted += push_item(ActionW'($urandom_range(0, 3)), $urandom_range(0, 4095),
                                 $urandom_range(0, 127));
      end else begin
        while (phase_cnt < 150) begin
          steady_flow = ($urandom_range(0, 5) == 0);
          r = push_burst();
          phase_cnt += r;
          n_counted += r;
        end
      end
      n_phase++;
    end
    steady_flow = 1'b0;
    wait_idle();

    $display("Covered %0d transactions over %0d settings: %0d samples, %0d captures done,",
             n_pushed, n_phase + 4, n_smp, n_done);
    $display("  %0d latches (%0d triggered, %0d free-running windows), %0d reads.",
             n_latch, n_trig_win, n_free_win, n_read);
    if (n_err == 0 && readout_q.size() == 0) begin
      $display("[scope_slew_trigger_capture] OK");
    end else begin
      $display("[scope_slew_trigger_capture] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("[scope_slew_trigger_capture] ERROR");
    $finish;
  end

endmodule

// ===== scope_slew_trigger_capture.f =====
hw/rtl/sstc_pkg.sv
hw/rtl/sstc_queue.sv
hw/rtl/sstc_front.sv
hw/rtl/sstc_back.sv
hw/rtl/scope_slew_trigger_capture.sv
tb/sv/tb.sv
